FILE: rtl/hpt_pkg.sv
// Package: shared constants and types of the homogeneous point transform.
package hpt_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int NUM_REGS          = 8;
  localparam int CFG_IDX_W         = 4;
  localparam int QUO_W             = 33;

  typedef logic [2:0][31:0] coord3_t;

  // Sideband carried alongside the divider lanes
  typedef struct packed {
    coord3_t    r;
    logic       sat;
    logic       div;
    logic [2:0] neg;
  } div_tag_t;

endpackage

FILE: rtl/hpt_in_if.sv
// Interface: input word channel (opcode and coordinates).
interface hpt_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;
  modport source (output valid, opcode, in_x, in_y, in_z, input ready);
  modport sink   (input valid, opcode, in_x, in_y, in_z, output ready);
endinterface

FILE: rtl/hpt_out_if.sv
// Interface: result word channel (transformed coordinates and flag).
interface hpt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        saturated;
  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

FILE: rtl/hpt_cfg_if.sv
// Interface: configuration write channel.
interface hpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/hpt_div.sv
// Module: three-lane pipelined restoring divider, one quotient bit per stage.
module hpt_div #(
  parameter int FRAC = hpt_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [2:0][32+FRAC-1:0]  in_num,
  input  logic [31:0]              in_den,
  input  hpt_pkg::div_tag_t        in_tag,
  output logic                     out_valid,
  output logic [2:0][hpt_pkg::QUO_W-1:0] out_q,
  output logic [2:0]               out_ovf,
  output hpt_pkg::div_tag_t        out_tag
);
  import hpt_pkg::*;

  localparam int NW = 32 + FRAC;
  localparam int HW = NW - QUO_W;

  logic                     v_r   [QUO_W+1];
  logic [2:0][31:0]         rem_r [QUO_W+1];
  logic [2:0][QUO_W-1:0]    sr_r  [QUO_W+1];
  logic [2:0]               ovf_r [QUO_W+1];
  logic [31:0]              den_r [QUO_W+1];
  div_tag_t                 tag_r [QUO_W+1];

  // Entry stage: split off the high dividend bits and flag quotients of 2^33 or more
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= {{(32-HW){1'b0}}, in_num[l][NW-1:QUO_W]};
        ovf_r[0][l] <= ({{(32-HW){1'b0}}, in_num[l][NW-1:QUO_W]} >= in_den);
        sr_r[0][l]  <= in_num[l][QUO_W-1:0];
      end
      den_r[0] <= in_den;
      tag_r[0] <= in_tag;
    end
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [2:0][32:0] rem2;
    logic [2:0]       ge;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem2[l] = {rem_r[s][l], sr_r[s][l][QUO_W-1]};
        ge[l]   = (rem2[l] >= {1'b0, den_r[s]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (adv) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          rem_r[s+1][l] <= ge[l] ? 32'(rem2[l] - {1'b0, den_r[s]}) : rem2[l][31:0];
          sr_r[s+1][l]  <= {sr_r[s][l][QUO_W-2:0], ge[l]};
        end
        ovf_r[s+1] <= ovf_r[s];
        den_r[s+1] <= den_r[s];
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  assign out_valid = v_r[QUO_W];
  assign out_q     = sr_r[QUO_W];
  assign out_ovf   = ovf_r[QUO_W];
  assign out_tag   = tag_r[QUO_W];

endmodule

FILE: rtl/homogeneous_point_transform_core.sv
// Top level: 4x4 homogeneous transform of 3-D points and vectors, Q format.
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+---------------------------------------
//  in_if   | in  | valid / ready | opcode, in_x, in_y, in_z
//  out_if  | out | valid / ready | out_x, out_y, out_z, saturated
//  cfg_if  | in  | valid / ready | index (0..7 rows/cols pairs), data 64b
//
//  One word enters per cycle while the pipe advances (see the stall rule below).
//  Stages: capture, 12 multiplies, row sums, floor and saturate, divide
//  entry, 33 quotient bits, sign and clip into the output register.
//  Reset (rst_n, synchronous) clears valid bits and loads the identity matrix.
//  A stall holds the whole pipe only when a word sits at the divider exit and
//  the output register is full and not taken; bubbles still advance.
//  Configuration writes are always ready; indices above 7 are dropped.
module homogeneous_point_transform_core #(
  parameter int FRACTION_BITS = hpt_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hpt_in_if.sink    in_if,
  hpt_out_if.source out_if,
  hpt_cfg_if.sink   cfg_if
);
  import hpt_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int SW = 66;
  localparam int NW = 32 + F;
  localparam logic [31:0] ONE = 32'(1) << F;

  // Identity matrix, register 7 first
  localparam logic [NUM_REGS-1:0][63:0] M_RESET = {
    {ONE, 32'd0}, 64'd0, {32'd0, ONE}, 64'd0,
    64'd0, {ONE, 32'd0}, 64'd0, {32'd0, ONE}
  };

  // Matrix registers
  logic [NUM_REGS-1:0][63:0] m_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= M_RESET;
    end else if (cfg_if.valid && (cfg_if.index < CFG_IDX_W'(NUM_REGS))) begin
      m_r[cfg_if.index[2:0]] <= cfg_if.data;
    end
  end

  function automatic logic [31:0] elem(input logic [NUM_REGS-1:0][63:0] m,
                                       input int row, input int col);
    logic [63:0] w;
    w = m[3'(row*2 + col/2)];
    return (col % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

  // Global advance: hold only when the divider exit would collide with a held result
  logic adv;
  logic div_v;
  logic out_valid_r;

  assign adv         = !(div_v && out_valid_r && !out_if.ready);
  assign in_if.ready = adv;

  // Stage 0: capture
  logic    s0_v_r, s0_vec_r;
  coord3_t s0_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_vec_r  <= in_if.opcode;
      s0_c_r[0] <= in_if.in_x;
      s0_c_r[1] <= in_if.in_y;
      s0_c_r[2] <= in_if.in_z;
    end
  end

  // Stage 1: twelve products, translation column latched alongside
  logic              s1_v_r, s1_pt_r;
  logic signed [63:0] s1_p_r [4][3];
  logic [3:0][31:0]  s1_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pt_r <= !s0_vec_r;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_p_r[r][c] <= $signed(elem(m_r, r, c)) * $signed(s0_c_r[c]);
        end
        s1_t_r[r] <= elem(m_r, r, 3);
      end
    end
  end

  // Stage 2: exact row sums at 2F fraction bits
  logic              s2_v_r, s2_pt_r;
  logic signed [SW-1:0] s2_sum_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pt_r <= s1_pt_r;
      for (int r = 0; r < 4; r++) begin
        s2_sum_r[r] <= SW'(s1_p_r[r][0]) + SW'(s1_p_r[r][1]) + SW'(s1_p_r[r][2])
                     + (s1_pt_r ? (SW'($signed(s1_t_r[r])) <<< F) : SW'(0));
      end
    end
  end

  // Stage 3: floor shift and clip to 32 bits
  logic signed [SW-1:0] shr [4];
  logic [3:0]           row_sat;
  logic [3:0][31:0]     row_val;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      shr[r]     = s2_sum_r[r] >>> F;
      row_sat[r] = !((&shr[r][SW-1:31]) || !(|shr[r][SW-1:31]));
      if (!row_sat[r]) begin
        row_val[r] = shr[r][31:0];
      end else if (shr[r][SW-1]) begin
        row_val[r] = 32'h8000_0000;
      end else begin
        row_val[r] = 32'h7FFF_FFFF;
      end
    end
  end

  logic             s3_v_r, s3_pt_r, s3_sat_r;
  logic [3:0][31:0] s3_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pt_r  <= s2_pt_r;
      s3_r_r   <= row_val;
      s3_sat_r <= (|row_sat[2:0]) || (s2_pt_r && row_sat[3]);
    end
  end

  // Divider entry: magnitudes and signs
  logic [2:0][NW-1:0] d_num;
  logic [31:0]        d_den;
  div_tag_t           d_tag;
  logic [31:0]        w_val;

  always_comb begin
    w_val     = s3_r_r[3];
    d_den     = w_val[31] ? 32'(-w_val) : w_val;
    d_tag.sat = s3_sat_r;
    d_tag.div = s3_pt_r && (w_val != 32'd0) && (w_val != ONE);
    for (int l = 0; l < 3; l++) begin
      d_tag.r[l]   = s3_r_r[l];
      d_tag.neg[l] = s3_r_r[l][31] ^ w_val[31];
      d_num[l]     = {(s3_r_r[l][31] ? 32'(-s3_r_r[l]) : s3_r_r[l]), {F{1'b0}}};
    end
  end

  logic [2:0][QUO_W-1:0] q;
  logic [2:0]            q_ovf;
  div_tag_t              q_tag;

  hpt_div #(.FRAC(F)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s3_v_r),
    .in_num    (d_num),
    .in_den    (d_den),
    .in_tag    (d_tag),
    .out_valid (div_v),
    .out_q     (q),
    .out_ovf   (q_ovf),
    .out_tag   (q_tag)
  );

  // Sign and clip the quotients, or pass the sums through
  coord3_t    fin_val;
  logic [2:0] lane_sat;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (q_tag.neg[l]) begin
        lane_sat[l] = q_ovf[l] || (q[l] > QUO_W'(33'h0_8000_0000));
      end else begin
        lane_sat[l] = q_ovf[l] || (q[l] > QUO_W'(33'h0_7FFF_FFFF));
      end
      if (!q_tag.div) begin
        fin_val[l] = q_tag.r[l];
      end else if (lane_sat[l]) begin
        fin_val[l] = q_tag.neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        fin_val[l] = q_tag.neg[l] ? 32'(-q[l][31:0]) : q[l][31:0];
      end
    end
  end

  // Output register
  logic    out_valid_nxt;
  coord3_t out_c_r;
  logic    out_sat_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && div_v) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && div_v) begin
      out_c_r   <= fin_val;
      out_sat_r <= q_tag.sat || (q_tag.div && (|lane_sat));
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_x     = out_c_r[0];
  assign out_if.out_y     = out_c_r[1];
  assign out_if.out_z     = out_c_r[2];
  assign out_if.saturated = out_sat_r;

endmodule
